FILE: rtl/core/fip_pkg.sv
package fip_pkg;

  localparam logic [63:0] DBL_ONE   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_ZERO  = 64'h0000_0000_0000_0000;
  localparam logic [10:0] EXP_ONES  = 11'h7FF;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;

  localparam int MANT_W = 53;
  localparam int PROD_W = 2 * MANT_W;
  localparam int HALF_W = 27;
  localparam int EXT_W  = 14;
  localparam int QUO_W  = 56;

  typedef logic signed [EXT_W-1:0] sexp_t;

endpackage

FILE: rtl/core/float_integer_power_core.sv
// Raises an IEEE-754 double to a signed integer power. The base is multiplied
// |exponent| times in order, each product rounded to nearest even, and for a
// negative exponent the reciprocal is taken by a rounded bit-serial divide.
// All mantissa products go through one 27x27 multiplier: a multiply sums its
// partial products in S_MUL, rounds in S_RNDA and S_RNDB and renormalizes in
// S_ANORM, which shifts once per leading zero when a subnormal has to be
// renormalized. The reciprocal develops a 56-bit quotient in S_DIV and is
// then rounded in S_RNDA and S_RNDB. A zero exponent, a zero base, an
// infinite or a NaN base go straight to S_DONE without multiplying. One
// item is worked on at a time; in_stall is high until it is done.
module float_integer_power_core #(
  parameter int EXPONENT_WIDTH = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [63:0]                      base_bits,
  input  logic signed [EXPONENT_WIDTH-1:0] exponent,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [63:0]                      result_bits,
  output logic                             zero_to_zero
);
  import fip_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BNORM = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_RNDA  = 4'd3;
  localparam logic [3:0] S_RNDB  = 4'd4;
  localparam logic [3:0] S_ANORM = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;

  // operands, kept normalized: value = mant * 2^(e - 1075)
  logic [MANT_W-1:0] bm, am;
  sexp_t be, ae;
  logic bs, as_;
  logic a_special;
  logic [63:0] acc_bits;
  logic negative;
  logic [EXPONENT_WIDTH-1:0] cnt;

  logic [2:0] step;
  logic [2*HALF_W-1:0] pp;
  logic [PROD_W-1:0] prod;
  logic sticky_in;
  sexp_t t;
  logic rsign;
  logic is_div;

  // rounding stage registers
  logic [MANT_W-1:0] rm;
  logic rb, rst_bit, rsubn;
  sexp_t rep;

  // divider
  logic [MANT_W:0] rem;
  logic [QUO_W-1:0] quo;
  logic [5:0] dcnt;

  logic [63:0] res;
  logic res_flag;

  assign in_stall = (state != S_IDLE);

  // accept decode
  logic base_zero, base_nan, base_inf, exp_zero;
  logic [EXPONENT_WIDTH-1:0] mag;
  assign base_zero = (base_bits[62:0] == 63'd0);
  assign base_nan  = (base_bits[62:52] == EXP_ONES) && (base_bits[51:0] != 52'd0);
  assign base_inf  = (base_bits[62:52] == EXP_ONES) && (base_bits[51:0] == 52'd0);
  assign exp_zero  = (exponent == '0);
  assign mag = exponent[EXPONENT_WIDTH-1] ? (~exponent + 1'b1) : exponent;

  // shared multiplier operand select
  logic [HALF_W-1:0] ma, mb;
  always_comb begin
    case (step)
      3'd0:    begin ma = am[HALF_W-1:0]; mb = bm[HALF_W-1:0]; end
      3'd1:    begin ma = am[HALF_W-1:0]; mb = {1'b0, bm[MANT_W-1:HALF_W]}; end
      3'd2:    begin ma = {1'b0, am[MANT_W-1:HALF_W]}; mb = bm[HALF_W-1:0]; end
      default: begin ma = {1'b0, am[MANT_W-1:HALF_W]}; mb = {1'b0, bm[MANT_W-1:HALF_W]}; end
    endcase
  end

  logic [PROD_W-1:0] addend;
  always_comb begin
    case (step)
      3'd1:      addend = PROD_W'(pp);
      3'd2, 3'd3: addend = PROD_W'(pp) << HALF_W;
      default:   addend = PROD_W'(pp) << (2 * HALF_W);
    endcase
  end

  // rounding, first half: align and collect sticky
  logic p_hi;
  logic [PROD_W-1:0] pn, pw;
  sexp_t ep, neg_amt;
  logic ep_subn, lost;
  logic [6:0] sh;
  always_comb begin
    p_hi    = prod[PROD_W-1];
    pn      = p_hi ? prod : {prod[PROD_W-2:0], 1'b0};
    ep      = t + (p_hi ? 14'sd1128 : 14'sd1127);
    ep_subn = (ep < 14'sd1);
    neg_amt = 14'sd1 - ep;
    if (!ep_subn) sh = 7'd0;
    else if (neg_amt > 14'sd108) sh = 7'd108;
    else sh = neg_amt[6:0];
    pw   = pn >> sh;
    lost = |(pn & ~({PROD_W{1'b1}} << sh));
  end

  // rounding, second half: round to nearest even and pack
  logic up;
  logic [MANT_W:0] r;
  sexp_t ef;
  logic ovf, unf;
  logic [MANT_W-1:0] nm;
  logic [63:0] rbits;
  always_comb begin
    up  = rb & (rst_bit | rm[0]);
    r   = {1'b0, rm} + (MANT_W+1)'(up);
    nm  = r[MANT_W] ? r[MANT_W:1] : r[MANT_W-1:0];
    ef  = rep + (r[MANT_W] ? 14'sd1 : 14'sd0);
    ovf = !rsubn && (ef > 14'sd2046);
    unf = rsubn && (r[MANT_W-1:0] == '0);
    if (ovf) rbits = {rsign, EXP_ONES, 52'd0};
    else if (rsubn) rbits = {rsign, 10'd0, r[MANT_W-1], r[51:0]};
    else rbits = {rsign, ef[10:0], nm[51:0]};
  end

  logic [MANT_W:0] rem2;
  assign rem2 = {rem[MANT_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            negative <= exponent[EXPONENT_WIDTH-1];
            cnt      <= mag;
            if (exp_zero) begin
              res      <= DBL_ONE;
              res_flag <= base_zero;
              state    <= S_DONE;
            end else if (base_zero) begin
              res      <= DBL_ZERO;
              res_flag <= 1'b0;
              state    <= S_DONE;
            end else if (base_nan) begin
              res      <= base_bits | QUIET_BIT;
              res_flag <= 1'b0;
              state    <= S_DONE;
            end else if (base_inf) begin
              // sign follows the parity of the power; reciprocal of inf is zero
              if (exponent[EXPONENT_WIDTH-1])
                res <= {base_bits[63] & mag[0], 63'd0};
              else
                res <= {base_bits[63] & mag[0], EXP_ONES, 52'd0};
              res_flag <= 1'b0;
              state    <= S_DONE;
            end else begin
              res_flag  <= 1'b0;
              bs        <= base_bits[63];
              bm        <= {base_bits[62:52] != 11'd0, base_bits[51:0]};
              be        <= (base_bits[62:52] == 11'd0) ? 14'sd1
                                                       : sexp_t'({3'b000, base_bits[62:52]});
              as_       <= 1'b0;
              am        <= {1'b1, 52'd0};
              ae        <= 14'sd1023;
              a_special <= 1'b0;
              acc_bits  <= DBL_ONE;
              step      <= 3'd0;
              state     <= S_BNORM;
            end
          end
        end
        S_BNORM: begin
          if (bm[MANT_W-1]) begin
            step  <= 3'd0;
            state <= S_MUL;
          end else begin
            bm <= {bm[MANT_W-2:0], 1'b0};
            be <= be - 14'sd1;
          end
        end
        S_MUL: begin
          if (a_special) begin
            // zero or infinity only flips sign from here on
            as_          <= as_ ^ bs;
            acc_bits[63] <= acc_bits[63] ^ bs;
            cnt          <= cnt - 1'b1;
            state        <= S_ANORM;
          end else begin
            if (step < 3'd4) pp <= ma * mb;
            if (step == 3'd0) begin
              prod      <= '0;
              t         <= ae + be - 14'sd2150;
              rsign     <= as_ ^ bs;
              sticky_in <= 1'b0;
              is_div    <= 1'b0;
            end else begin
              prod <= prod + addend;
            end
            if (step == 3'd4) state <= S_RNDA;
            else step <= step + 3'd1;
          end
        end
        S_RNDA: begin
          rm      <= pw[PROD_W-1:MANT_W];
          rb      <= pw[MANT_W-1];
          rst_bit <= (|pw[MANT_W-2:0]) | lost | sticky_in;
          rep     <= ep;
          rsubn   <= ep_subn;
          state   <= S_RNDB;
        end
        S_RNDB: begin
          if (is_div) begin
            res   <= rbits;
            state <= S_DONE;
          end else begin
            acc_bits  <= unf ? {rsign, 63'd0} : rbits;
            as_       <= rsign;
            a_special <= ovf | unf;
            am        <= rsubn ? r[MANT_W-1:0] : nm;
            ae        <= rsubn ? 14'sd1 : ef;
            cnt       <= cnt - 1'b1;
            state     <= S_ANORM;
          end
        end
        S_ANORM: begin
          if (!a_special && !am[MANT_W-1]) begin
            am <= {am[MANT_W-2:0], 1'b0};
            ae <= ae - 14'sd1;
          end else if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            step  <= 3'd0;
            state <= S_MUL;
          end
        end
        S_FIN: begin
          if (!negative) begin
            res   <= acc_bits;
            state <= S_DONE;
          end else if (a_special) begin
            // reciprocal of zero is inf, of inf is zero, sign kept
            res   <= (acc_bits[62:0] == 63'd0) ? {as_, EXP_ONES, 52'd0} : {as_, 63'd0};
            state <= S_DONE;
          end else begin
            rem   <= (MANT_W+1)'(1) << 51;
            quo   <= '0;
            dcnt  <= 6'(QUO_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, am}) begin
            rem <= rem2 - {1'b0, am};
            quo <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            rem <= rem2;
            quo <= {quo[QUO_W-2:0], 1'b0};
          end
          if (dcnt == 6'd0) state <= S_RNDA;
          else dcnt <= dcnt - 6'd1;
          prod      <= {quo[QUO_W-2:0], rem2 >= {1'b0, am}, 50'd0};
          sticky_in <= (rem2 >= {1'b0, am}) ? (rem2 != {1'b0, am}) : (rem2 != '0);
          t         <= 14'sd918 - ae;
          rsign     <= as_;
          is_div    <= 1'b1;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            result_bits  <= res;
            zero_to_zero <= res_flag;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted item did not start work");

  a_base_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> bm[MANT_W-1])
    else $error("base mantissa not normalized in multiply");

  a_div_finite: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (!a_special && am[MANT_W-1]))
    else $error("divide started on special or unnormalized value");

  a_flag_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_to_zero) |-> (result_bits == DBL_ONE))
    else $error("zero to zero result is not one");

endmodule

FILE: tb/sv/tb_float_integer_power_core.sv
`timescale 1ns / 100ps

module tb_float_integer_power_core;
  import fip_pkg::*;

  localparam int EW = 11;
  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int RANDOM_ITEMS = 520;

  typedef struct {
    logic [63:0] result;
    logic        flag;
  } power_result_t;

  class power_scoreboard;
    power_result_t pending_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // work out base**exp with one rounded multiply per step, as the block does
    function void note_input(logic [63:0] base, logic signed [EW-1:0] exp);
      int n;
      int mag;
      real acc;
      real bv;
      logic [63:0] acc_bits;
      power_result_t r;
      n = exp;
      r.flag = 1'b0;
      if (n == 0) begin
        r.result = DBL_ONE;
        r.flag = (base[62:0] == '0);
      end else if (base[62:0] == '0) begin
        r.result = DBL_ZERO;
      end else begin
        mag = (n < 0) ? -n : n;
        bv = $bitstoreal(base);
        acc = 1.0;
        for (int i = 0; i < mag; i++) acc = acc * bv;
        acc_bits = $realtobits(acc);
        if (n > 0) r.result = acc_bits;
        else if (acc_bits[62:0] == '0) r.result = {acc_bits[63], EXP_ONES, 52'd0};
        else r.result = $realtobits(1.0 / acc);
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [63:0] result, logic flag);
      power_result_t e;
      if (pending_q.size() == 0) begin
        $error("result %h with no transfer outstanding", result);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (result !== e.result) begin
        $error("result_bits: expected %h, actual %h", e.result, result);
        errors++;
      end
      if (flag !== e.flag) begin
        $error("zero_to_zero: expected %b, actual %b", e.flag, flag);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [63:0] base_bits;
  logic signed [EW-1:0] exponent;
  logic out_valid;
  logic out_stall;
  logic [63:0] result_bits;
  logic zero_to_zero;

  power_scoreboard power_sb;
  bit idle_on;
  longint cycles;

  float_integer_power_core #(.EXPONENT_WIDTH(EW)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .base_bits(base_bits),
    .exponent(exponent),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_bits(result_bits),
    .zero_to_zero(zero_to_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_float_integer_power_core: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) power_sb.check_result(result_bits, zero_to_zero);
  end

  // receiver backpressure in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_power(logic [63:0] base, logic signed [EW-1:0] exp);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    base_bits <= base;
    exponent <= exp;
    do @(posedge clk); while (in_stall);
    power_sb.note_input(base, exp);
  endtask

  function automatic logic [63:0] pick_base();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) // magnitude near one keeps long powers finite
      return {1'($urandom), 11'($urandom_range(1019, 1027)), $urandom(), 20'($urandom)};
    if (sel < 85) return {$urandom(), $urandom()};
    if (sel < 92) return {1'($urandom), 11'd0, 20'($urandom), $urandom()};
    case ($urandom_range(0, 3))
      0: return {1'($urandom), 63'd0};
      1: return {1'($urandom), EXP_ONES, 52'd0};
      2: return {1'($urandom), EXP_ONES, 20'($urandom) | 20'h1, $urandom()};
      default: return {1'($urandom), 11'd1023, 52'd0};
    endcase
  endfunction

  function automatic logic signed [EW-1:0] pick_exp();
    if ($urandom_range(0, 99) < 88) return EW'($signed($urandom_range(0, 40)) - 20);
    return EW'($urandom());
  endfunction

  initial begin
    logic [63:0] dir_base[$];
    logic signed [EW-1:0] dir_exp[$];
    cycles = 0;
    power_sb = new();
    idle_on = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    base_bits = '0;
    exponent = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_base = '{64'h0, 64'h8000_0000_0000_0000, 64'h0, 64'h8000_0000_0000_0000,
                 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h7FF4_0000_0000_0000,
                 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
                 64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h3FE0_0000_0000_0000,
                 64'hBFF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'hC000_0000_0000_0000,
                 64'h3FF0_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF8_0000_0000_0000};
    dir_exp = '{11'sd0, 11'sd0, -11'sd5, 11'sd1023, 11'sd3, -11'sd3, 11'sd2, 11'sd0,
                -11'sd1, -11'sd2, 11'sd1, -11'sd1, 11'sd2, 11'sh400, 11'sd1023,
                11'sd1023, 11'sh400, 11'sd1023, -11'sd1, 11'sd1023, 11'sd1, 11'sd7};
    foreach (dir_base[i]) send_power(dir_base[i], dir_exp[i]);

    idle_on = 1'b1;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (power_sb.outstanding() != 0) @(posedge clk);
        @(posedge clk);
      end
      if (k == RANDOM_ITEMS - 60) idle_on = 1'b0;
      send_power(pick_base(), pick_exp());
    end
    in_valid <= 1'b0;

    while (power_sb.outstanding() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (power_sb.errors == 0 && power_sb.outstanding() == 0)
      $display("tb_float_integer_power_core: clean");
    else
      $display("tb_float_integer_power_core: errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/fip_pkg.sv
rtl/core/float_integer_power_core.sv
tb/sv/tb_float_integer_power_core.sv
